@@ rtl/wavetable_voice_mixer_top_defines.svh @@
// Assertion macros shared by the mixer's RTL.
`ifndef WAVETABLE_VOICE_MIXER_TOP_DEFINES_SVH
`define WAVETABLE_VOICE_MIXER_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define WVM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define WVM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wvm_pkg.sv @@
package wvm_pkg;

    localparam int VOICES_DEF          = 16;
    localparam int SAMPLE_DEPTH_DEF    = 65536;
    localparam int PHASE_FRAC_BITS_DEF = 16;

    localparam int VOICE_W = 4;
    localparam int ADDR_W  = 16;
    localparam int SMP_W   = 16;
    localparam int LEN_W   = 17;
    localparam int STEP_W  = 24;
    localparam int GAIN_W  = 16;
    localparam int DIR_W   = 16;
    localparam int GEFF_W  = 18;
    localparam int F_W     = 32;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int Q28_SHIFT = 28;
    localparam int MIX_SHIFT = 14;
    localparam logic signed [F_W-1:0] Q28_ONE         = 32'sd268435456;
    localparam logic signed [F_W-1:0] Q28_POINT_EIGHT = 32'sd214748365;
    localparam int MIX_LIMIT = 32000;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_SETUP   = 2'd1,
        ACT_STOP    = 2'd2,
        ACT_PRODUCE = 2'd3
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic [VOICE_W-1:0]        voice;
        logic [ADDR_W-1:0]         address;
        logic signed [SMP_W-1:0]   sample_value;
        logic [LEN_W-1:0]          sound_length;
        logic [STEP_W-1:0]         phase_step;
        logic signed [GAIN_W-1:0]  gain;
        logic                      loop_flag;
        logic                      ambient_flag;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
    } t_in_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] mixed_sample;
    } t_out_word;

endpackage

@@ rtl/wvm_in_if.sv @@
interface wvm_in_if;
    import wvm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/wvm_out_if.sv @@
interface wvm_out_if;
    import wvm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/wvm_mul.sv @@
module wvm_mul (
    input  logic                                 i_clk,
    input  logic signed [wvm_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [wvm_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [wvm_pkg::MUL_P_W-1:0]   o_prod
);
    import wvm_pkg::*;

    logic signed [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule

@@ rtl/wvm_smem.sv @@
module wvm_smem #(
    parameter int SAMPLE_DEPTH = wvm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [$clog2(SAMPLE_DEPTH)-1:0]     i_wr_addr,
    input  logic signed [wvm_pkg::SMP_W-1:0]    i_wr_data,
    input  logic [$clog2(SAMPLE_DEPTH)-1:0]     i_rd_addr,
    output logic signed [wvm_pkg::SMP_W-1:0]    o_rd_data
);
    import wvm_pkg::*;

    logic signed [SMP_W-1:0] r_mem [SAMPLE_DEPTH];
    logic signed [SMP_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ rtl/wavetable_voice_mixer_top.sv @@
// Wavetable voice mixer. Write, set-up and stop words are handled in the idle state
// as they are accepted. A produce word visits every voice in turn through one shared
// multiplier: the scan state skips an inactive voice, an active voice that has run
// out (zero length or a one-shot past its end) is stopped in the check state, an
// active ambient voice passes the gain, effective-gain and accumulate states, an
// active directional voice first passes the direction states D1 to D3, and a looping
// voice then works off the phase wrap in a restoring remainder unit one bit a cycle
// and writes its phase back. A closing state, held while the previous mixed sample
// still waits at the output, ends the mix; the new sample shows in the output
// register the cycle after it. No new word is taken while a produce word is mixed.
module wavetable_voice_mixer_top #(
    parameter int VOICES          = wvm_pkg::VOICES_DEF,
    parameter int SAMPLE_DEPTH    = wvm_pkg::SAMPLE_DEPTH_DEF,
    parameter int PHASE_FRAC_BITS = wvm_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wvm_in_if.sink      i_in,
    wvm_out_if.source   o_out
);
    import wvm_pkg::*;
    `include "wavetable_voice_mixer_top_defines.svh"

    localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW        = $clog2(SAMPLE_DEPTH);
    localparam int PW        = LEN_W + 1 + PHASE_FRAC_BITS;
    localparam int IW        = PW - PHASE_FRAC_BITS;
    localparam int MOD_STEPS = STEP_W + 1 - PHASE_FRAC_BITS;
    localparam int MCW       = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam int MW        = LEN_W + STEP_W + 1;
    localparam int SUM_W     = (AW > IW + 1) ? AW : IW + 1;
    localparam int ACC_W     = 34 + $clog2(VOICES);

    typedef struct packed {
        logic [ADDR_W-1:0]        base;
        logic [LEN_W-1:0]         len;
        logic [STEP_W-1:0]        step;
        logic signed [GAIN_W-1:0] gain;
        logic                     loop;
        logic                     ambient;
        logic signed [DIR_W-1:0]  dx;
        logic signed [DIR_W-1:0]  dy;
        logic signed [DIR_W-1:0]  dz;
    } t_voice_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHECK, S_D1, S_D2, S_D3, S_GAIN, S_GEFF, S_ACC,
        S_MOD, S_WB, S_OUT
    } t_state;

    t_state                    r_state, n_state;
    logic [VW-1:0]             r_vidx, n_vidx;
    logic [VOICES-1:0]         r_active, n_active;
    logic signed [DIR_W-1:0]   r_lis [3];
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [F_W-1:0]     r_f, n_f;
    logic                      r_use, n_use;
    logic [MW-1:0]             r_rem, n_rem;
    logic [MW-1:0]             r_div, n_div;
    logic [MCW-1:0]            r_mcnt, n_mcnt;
    logic [AW-1:0]             r_saddr, n_saddr;
    logic                      r_out_valid, n_out_valid;
    logic signed [SMP_W-1:0]   r_out_data, n_out_data;

    t_voice_cfg                r_cfg_mem [VOICES];
    logic [PW-1:0]             r_ph_mem [VOICES];
    t_voice_cfg                r_cfg_q;
    logic [PW-1:0]             r_ph_q;

    logic                      in_acc, v_in_ok;
    logic [VW-1:0]             v_in;
    logic                      cfg_we, ph_we;
    logic [VW-1:0]             ph_waddr;
    logic [PW-1:0]             ph_wdata;
    t_voice_cfg                cfg_wdata;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [SMP_W-1:0]   smp_q;

    logic [IW-1:0]             idx;
    logic                      kill;
    logic [SUM_W-1:0]          addr_sum;
    logic signed [F_W-1:0]     f_cl;
    logic signed [MUL_P_W-1:0] g_round;
    logic signed [MUL_P_W-1:0] g_sh;
    logic signed [GEFF_W-1:0]  geff;
    logic signed [ACC_W-1:0]   acc_round;
    logic signed [ACC_W-1:0]   res_full;
    logic [PW-1:0]             ph_sum;
    logic                      last_v;

    wvm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    wvm_smem #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_smem (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && (i_in.data.action == ACT_WRITE)),
        .i_wr_addr (AW'(i_in.data.address)),
        .i_wr_data (i_in.data.sample_value),
        .i_rd_addr (r_saddr),
        .o_rd_data (smp_q)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign in_acc           = i_in.valid && i_in.ready;
    assign v_in_ok          = (32'(i_in.data.voice) < VOICES);
    assign v_in             = VW'(i_in.data.voice);
    assign o_out.valid      = r_out_valid;
    assign o_out.data.mixed_sample = r_out_data;

    assign idx      = r_ph_q[PW-1:PHASE_FRAC_BITS];
    assign kill     = (r_cfg_q.len == '0) ||
                      (!r_cfg_q.loop && (idx >= IW'(r_cfg_q.len)));
    assign addr_sum = SUM_W'(r_cfg_q.base) + SUM_W'(idx);
    assign f_cl     = (r_f > Q28_ONE) ? Q28_ONE : r_f;
    assign g_round  = prod + (prod[MUL_P_W-1] ?
                      MUL_P_W'((64'sd1 <<< Q28_SHIFT) - 64'sd1) : '0);
    assign g_sh     = g_round >>> Q28_SHIFT;
    assign geff     = g_sh[GEFF_W-1:0];
    assign acc_round = r_acc + (r_acc[ACC_W-1] ?
                       ACC_W'((1 << MIX_SHIFT) - 1) : '0);
    assign res_full = acc_round >>> MIX_SHIFT;
    assign ph_sum   = r_ph_q + PW'(r_cfg_q.step);
    assign last_v   = (32'(r_vidx) == VOICES - 1);

    assign cfg_wdata = '{base: i_in.data.address, len: i_in.data.sound_length,
                         step: i_in.data.phase_step, gain: i_in.data.gain,
                         loop: i_in.data.loop_flag, ambient: i_in.data.ambient_flag,
                         dx: i_in.data.dir_x, dy: i_in.data.dir_y, dz: i_in.data.dir_z};

    always_comb begin
        n_state     = r_state;
        n_vidx      = r_vidx;
        n_active    = r_active;
        n_acc       = r_acc;
        n_f         = r_f;
        n_use       = r_use;
        n_rem       = r_rem;
        n_div       = r_div;
        n_mcnt      = r_mcnt;
        n_saddr     = r_saddr;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_data  = r_out_data;
        mul_a       = '0;
        mul_b       = '0;
        cfg_we      = 1'b0;
        ph_we       = 1'b0;
        ph_waddr    = r_vidx;
        ph_wdata    = PW'(r_rem);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.data.action)
                        ACT_SETUP: begin
                            if (v_in_ok) begin
                                cfg_we       = 1'b1;
                                ph_we        = 1'b1;
                                ph_waddr     = v_in;
                                ph_wdata     = '0;
                                n_active[v_in] = 1'b1;
                            end
                        end
                        ACT_STOP: begin
                            if (v_in_ok) begin
                                n_active[v_in] = 1'b0;
                            end
                        end
                        ACT_PRODUCE: begin
                            n_vidx  = '0;
                            n_acc   = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_active[r_vidx]) begin
                    n_state = S_CHECK;
                end else if (last_v) begin
                    n_state = S_OUT;
                end else begin
                    n_vidx = r_vidx + 1'b1;
                end
            end
            S_CHECK: begin
                if (kill) begin
                    n_active[r_vidx] = 1'b0;
                    n_state = last_v ? S_OUT : S_SCAN;
                    n_vidx  = last_v ? r_vidx : r_vidx + 1'b1;
                end else begin
                    n_saddr = addr_sum[AW-1:0];
                    if (r_cfg_q.ambient) begin
                        n_f     = Q28_ONE;
                        n_state = S_GAIN;
                    end else begin
                        mul_a   = MUL_A_W'(r_cfg_q.dx);
                        mul_b   = MUL_B_W'(r_lis[0]);
                        n_state = S_D1;
                    end
                end
            end
            S_D1: begin
                n_f     = Q28_POINT_EIGHT + $signed(prod[F_W-1:0]);
                mul_a   = MUL_A_W'(r_cfg_q.dy);
                mul_b   = MUL_B_W'(r_lis[1]);
                n_state = S_D2;
            end
            S_D2: begin
                n_f     = r_f + $signed(prod[F_W-1:0]);
                mul_a   = MUL_A_W'(r_cfg_q.dz);
                mul_b   = MUL_B_W'(r_lis[2]);
                n_state = S_D3;
            end
            S_D3: begin
                n_f     = r_f + $signed(prod[F_W-1:0]);
                n_state = S_GAIN;
            end
            S_GAIN: begin
                mul_a   = f_cl;
                mul_b   = MUL_B_W'(r_cfg_q.gain);
                n_state = S_GEFF;
            end
            S_GEFF: begin
                mul_a   = MUL_A_W'(smp_q);
                mul_b   = geff;
                n_use   = (r_cfg_q.step != '0) && (geff > 18'sd0);
                n_rem   = MW'(ph_sum);
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_use) begin
                    n_acc = r_acc + $signed(prod[ACC_W-1:0]);
                end
                if (r_cfg_q.loop) begin
                    n_div   = MW'(r_cfg_q.len) << (PHASE_FRAC_BITS + MOD_STEPS - 1);
                    n_mcnt  = MCW'(MOD_STEPS - 1);
                    n_state = S_MOD;
                end else begin
                    ph_we = 1'b1;
                    if (r_rem[PW-1:PHASE_FRAC_BITS] >= IW'(r_cfg_q.len)) begin
                        n_active[r_vidx] = 1'b0;
                    end
                    n_state = last_v ? S_OUT : S_SCAN;
                    n_vidx  = last_v ? r_vidx : r_vidx + 1'b1;
                end
            end
            S_MOD: begin
                if (r_rem >= r_div) begin
                    n_rem = r_rem - r_div;
                end
                n_div = r_div >> 1;
                if (r_mcnt == '0) begin
                    n_state = S_WB;
                end else begin
                    n_mcnt = r_mcnt - 1'b1;
                end
            end
            S_WB: begin
                ph_we   = 1'b1;
                n_state = last_v ? S_OUT : S_SCAN;
                n_vidx  = last_v ? r_vidx : r_vidx + 1'b1;
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    if (res_full > ACC_W'(MIX_LIMIT)) begin
                        n_out_data = SMP_W'(MIX_LIMIT);
                    end else if (res_full < ACC_W'(-MIX_LIMIT)) begin
                        n_out_data = SMP_W'(-MIX_LIMIT);
                    end else begin
                        n_out_data = res_full[SMP_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vidx      <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vidx      <= n_vidx;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
        r_acc      <= n_acc;
        r_f        <= n_f;
        r_use      <= n_use;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_mcnt     <= n_mcnt;
        r_saddr    <= n_saddr;
        r_out_data <= n_out_data;
        if (in_acc && (i_in.data.action == ACT_PRODUCE)) begin
            r_lis[0] <= i_in.data.dir_x;
            r_lis[1] <= i_in.data.dir_y;
            r_lis[2] <= i_in.data.dir_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cfg_we) begin
            r_cfg_mem[v_in] <= cfg_wdata;
        end
        if (ph_we) begin
            r_ph_mem[ph_waddr] <= ph_wdata;
        end
        r_cfg_q <= r_cfg_mem[r_vidx];
        r_ph_q  <= r_ph_mem[r_vidx];
    end

    `WVM_ASSERT_IMP(a_out_range, o_out.valid, (o_out.data.mixed_sample <= 16'sd32000) && (o_out.data.mixed_sample >= -16'sd32000), "mixed sample out of range")
    `WVM_ASSERT_NXT(a_produce_busy, in_acc && (i_in.data.action == ACT_PRODUCE), !i_in.ready, "produce did not start the mix")
    `WVM_ASSERT_IMP(a_out_from_mix, $rose(o_out.valid), $past(r_state) == S_OUT, "result appeared outside the mix end")
    `WVM_ASSERT_IMP(a_vidx_range, r_state != S_IDLE, 32'(r_vidx) < VOICES, "voice counter out of range")
endmodule
